/* sv/ghist_pkg.sv */
package ghist_pkg;

  // default sizes
  localparam int unsigned MAX_BINS_DEF     = 4096;
  localparam int unsigned MAX_FEATURES_DEF = 256;

  // field widths
  localparam int unsigned FEAT_W  = 8;
  localparam int unsigned BIN_W   = 16;
  localparam int unsigned ROW_W   = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned OFS_W   = 13;
  localparam int unsigned CNT13_W = 13;

  // bin plus offset never wraps in this width
  localparam int unsigned IDX_W = 17;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSE_MODE = 1'b1;

  // reset values of the registers
  localparam logic [CNT13_W-1:0] BIN_COUNT_RST  = 13'd4096;
  localparam logic               DENSE_MODE_RST = 1'b1;

  typedef enum logic [1:0] {
    REQ_ACCUM    = 2'd0,
    REQ_READ     = 2'd1,
    REQ_LOAD_OFS = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    req_e                     req_type;
    logic [FEAT_W-1:0]        feature;
    logic [BIN_W-1:0]         bin;
    logic signed [ROW_W-1:0]  grad;
    logic signed [ROW_W-1:0]  hess;
    logic [OFS_W-1:0]         offset_value;
  } req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] grad_sum;
    logic signed [SUM_W-1:0] hess_sum;
    logic                    bin_valid;
  } res_t;

  // write and read enables of a memory port
  typedef struct packed {
    logic we;
    logic rd;
  } mem_ctl_t;

endpackage

/* sv/ghist_ram.sv */
module ghist_ram #(
  parameter int unsigned WIDTH  = ghist_pkg::SUM_W,
  parameter int unsigned DEPTH  = ghist_pkg::MAX_BINS_DEF,
  parameter int unsigned ADDR_W = $clog2(ghist_pkg::MAX_BINS_DEF)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, read before write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ghist_sat_add.sv */
module ghist_sat_add (
  input  logic signed [ghist_pkg::SUM_W-1:0] acc_i,
  input  logic signed [ghist_pkg::ROW_W-1:0] delta_i,
  output logic signed [ghist_pkg::SUM_W-1:0] sum_o
);

  localparam int unsigned SW = ghist_pkg::SUM_W;
  localparam int unsigned RW = ghist_pkg::ROW_W;

  logic [SW:0] wide_sum;

  // one guard bit catches overflow of the 48-bit sum
  assign wide_sum = {acc_i[SW-1], acc_i} + {{(SW+1-RW){delta_i[RW-1]}}, delta_i};

  // clamp to the signed limits
  always_comb begin
    if (wide_sum[SW] != wide_sum[SW-1]) begin
      sum_o = wide_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_o = wide_sum[SW-1:0];
    end
  end

endmodule

/* sv/gradient_histogram_accumulator.sv */
// Gradient histogram accumulator. Items are issued with start_i while busy_o is low.
// Accumulate and read items pass the accept cycle, an address state (an accumulate
// in dense mode adds the feature offset read from the offset memory) and an execute
// state that writes an accumulate's saturated sums back to the bin memory; an offset
// load is written in its address state; a clear sweeps the bin memory one entry a
// cycle. After reset the block is busy while both memories are zeroed. A read returns
// its result on res_o, marked by res_valid_o for exactly one cycle, in the cycle after
// the item finishes; results cannot be held off. Configuration writes are always
// taken (cfg_ready_o is high) and must only be issued while the block is idle.
module gradient_histogram_accumulator #(
  parameter int unsigned MAX_BINS     = ghist_pkg::MAX_BINS_DEF,
  parameter int unsigned MAX_FEATURES = ghist_pkg::MAX_FEATURES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  ghist_pkg::req_t                    req_i,
  output logic                               res_valid_o,
  output ghist_pkg::res_t                    res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ghist_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ghist_pkg::CNT13_W-1:0]      cfg_data_i
);

  localparam int unsigned SW     = ghist_pkg::SUM_W;
  localparam int unsigned IDX_W  = ghist_pkg::IDX_W;
  localparam int unsigned OFS_W  = ghist_pkg::OFS_W;
  localparam int unsigned BA_W   = $clog2(MAX_BINS);
  localparam int unsigned FA_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned SWEEP  = (MAX_BINS > MAX_FEATURES) ? MAX_BINS : MAX_FEATURES;
  localparam int unsigned CNT_W  = $clog2(SWEEP);
  localparam logic [CNT_W-1:0] INIT_LAST  = CNT_W'(SWEEP - 1);
  localparam logic [CNT_W-1:0] CLEAR_LAST = CNT_W'(MAX_BINS - 1);
  localparam logic [IDX_W-1:0] BINS_LIM   = IDX_W'(MAX_BINS);

  ghist_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  ghist_pkg::req_t   req_q;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              hit_q, hit_d;
  logic [ghist_pkg::CNT13_W-1:0] bin_count_q;
  logic              dense_q;
  ghist_pkg::res_t   res_q;
  logic              res_valid_q;

  logic              accept;
  logic [IDX_W-1:0]  limit;
  logic              feat_ok;
  logic [OFS_W-1:0]  ofs_add;

  ghist_pkg::mem_ctl_t    bin_ctl, ofs_ctl;
  logic [BA_W-1:0]        bin_addr;
  logic [2*SW-1:0]        bin_wdata, bin_rdata;
  logic [FA_W-1:0]        ofs_addr;
  logic [OFS_W-1:0]       ofs_wdata, ofs_rdata;
  logic signed [SW-1:0]   grad_new, hess_new;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != ghist_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // effective bin limit
  assign limit = (IDX_W'(bin_count_q) > BINS_LIM) ? BINS_LIM : IDX_W'(bin_count_q);

  assign feat_ok = (32'(req_q.feature) < 32'(MAX_FEATURES));
  assign ofs_add = dense_q ? ofs_rdata : '0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= ghist_pkg::BIN_COUNT_RST;
      dense_q     <= ghist_pkg::DENSE_MODE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ghist_pkg::CFG_BIN_COUNT:  bin_count_q <= cfg_data_i;
        ghist_pkg::CFG_DENSE_MODE: dense_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer: next state, memory controls and addresses
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    hit_d     = hit_q;
    bin_ctl   = '0;
    ofs_ctl   = '0;
    bin_addr  = idx_q[BA_W-1:0];
    bin_wdata = {grad_new, hess_new};
    ofs_addr  = FA_W'(req_i.feature);
    ofs_wdata = req_q.offset_value;
    case (state_q)
      ghist_pkg::ST_INIT: begin
        bin_ctl.we = (32'(cnt_q) < MAX_BINS);
        ofs_ctl.we = (32'(cnt_q) < MAX_FEATURES);
        bin_addr   = cnt_q[BA_W-1:0];
        bin_wdata  = '0;
        ofs_addr   = cnt_q[FA_W-1:0];
        ofs_wdata  = '0;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == INIT_LAST) begin
          state_d = ghist_pkg::ST_IDLE;
        end
      end
      ghist_pkg::ST_IDLE: begin
        // offset read for the incoming item
        ofs_ctl.rd = accept;
        if (accept) begin
          state_d = ghist_pkg::ST_ADDR;
        end
      end
      ghist_pkg::ST_ADDR: begin
        ofs_addr = FA_W'(req_q.feature);
        case (req_q.req_type)
          ghist_pkg::REQ_ACCUM: begin
            idx_d      = IDX_W'(req_q.bin) + IDX_W'(ofs_add);
            hit_d      = (idx_d < limit) && (!dense_q || feat_ok);
            bin_ctl.rd = 1'b1;
            bin_addr   = idx_d[BA_W-1:0];
            state_d    = ghist_pkg::ST_EXEC;
          end
          ghist_pkg::REQ_READ: begin
            idx_d      = IDX_W'(req_q.bin);
            hit_d      = (idx_d < limit);
            bin_ctl.rd = 1'b1;
            bin_addr   = idx_d[BA_W-1:0];
            state_d    = ghist_pkg::ST_EXEC;
          end
          ghist_pkg::REQ_LOAD_OFS: begin
            ofs_ctl.we = feat_ok;
            state_d    = ghist_pkg::ST_IDLE;
          end
          ghist_pkg::REQ_CLEAR: begin
            cnt_d   = '0;
            state_d = ghist_pkg::ST_CLEAR;
          end
          default: state_d = ghist_pkg::ST_IDLE;
        endcase
      end
      ghist_pkg::ST_EXEC: begin
        // write back the saturated sums of an accumulate
        bin_ctl.we = hit_q && (req_q.req_type == ghist_pkg::REQ_ACCUM);
        state_d    = ghist_pkg::ST_IDLE;
      end
      ghist_pkg::ST_CLEAR: begin
        bin_ctl.we = 1'b1;
        bin_addr   = cnt_q[BA_W-1:0];
        bin_wdata  = '0;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CLEAR_LAST) begin
          state_d = ghist_pkg::ST_IDLE;
        end
      end
      default: state_d = ghist_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ghist_pkg::ST_INIT;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      res_valid_q <= (state_q == ghist_pkg::ST_EXEC) &&
                     (req_q.req_type == ghist_pkg::REQ_READ);
    end
  end

  // item, bin index and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    idx_q <= idx_d;
    if (state_q == ghist_pkg::ST_EXEC) begin
      res_q.grad_sum  <= hit_q ? bin_rdata[2*SW-1:SW] : '0;
      res_q.hess_sum  <= hit_q ? bin_rdata[SW-1:0] : '0;
      res_q.bin_valid <= hit_q;
    end
  end

  // saturating update of both sums
  ghist_sat_add u_grad_add (
    .acc_i   (bin_rdata[2*SW-1:SW]),
    .delta_i (req_q.grad),
    .sum_o   (grad_new)
  );

  ghist_sat_add u_hess_add (
    .acc_i   (bin_rdata[SW-1:0]),
    .delta_i (req_q.hess),
    .sum_o   (hess_new)
  );

  // gradient and hessian sums, one entry per bin
  ghist_ram #(
    .WIDTH  (2 * SW),
    .DEPTH  (MAX_BINS),
    .ADDR_W (BA_W)
  ) u_bin_mem (
    .clk_i   (clk_i),
    .we_i    (bin_ctl.we),
    .re_i    (bin_ctl.rd),
    .addr_i  (bin_addr),
    .wdata_i (bin_wdata),
    .rdata_o (bin_rdata)
  );

  // first global bin of each feature
  ghist_ram #(
    .WIDTH  (OFS_W),
    .DEPTH  (MAX_FEATURES),
    .ADDR_W (FA_W)
  ) u_ofs_mem (
    .clk_i   (clk_i),
    .we_i    (ofs_ctl.we),
    .re_i    (ofs_ctl.rd),
    .addr_i  (ofs_addr),
    .wdata_i (ofs_wdata),
    .rdata_o (ofs_rdata)
  );

  // result strobe lasts a single cycle
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for more than one cycle");

  // out-of-range reads return zero sums
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.bin_valid) |-> (res_o.grad_sum == '0 && res_o.hess_sum == '0))
    else $error("out-of-range read returned nonzero sums");

  // an accepted item makes the block busy
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("block not busy after an accepted item");

  // results only come out once the item is finished
  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result presented while the block is busy");

  // no bin write while an item is being addressed
  a_no_early_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ghist_pkg::ST_ADDR) |-> !bin_ctl.we)
    else $error("bin memory written in the address cycle");

endmodule

/* sim/gradient_histogram_accumulator_tb.sv */
`timescale 1ns / 100ps

module gradient_histogram_accumulator_tb;

  localparam int unsigned FEAT_W = ghist_pkg::FEAT_W;
  localparam int unsigned BIN_W  = ghist_pkg::BIN_W;
  localparam int unsigned ROW_W  = ghist_pkg::ROW_W;
  localparam int unsigned SUM_W  = ghist_pkg::SUM_W;
  localparam int unsigned OFS_W  = ghist_pkg::OFS_W;
  localparam int unsigned IDX_W  = ghist_pkg::IDX_W;

  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int unsigned WATCHDOG_CYCLES = 20000;
  localparam int unsigned RAIL_ADDS = 8;
  localparam int unsigned PHASE_ITEMS = 455;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start_i = 1'b0;
  logic                            busy_o;
  ghist_pkg::req_t                 req_i = '0;
  logic                            res_valid_o;
  ghist_pkg::res_t                 res_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [ghist_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ghist_pkg::CNT13_W-1:0]   cfg_data_i = '0;

  // items waiting to be issued and readbacks waiting to come back
  ghist_pkg::req_t pending_items[$];
  ghist_pkg::res_t readback_q[$];

  // shadow of the histogram tables and registers
  longint           grad_tbl[ghist_pkg::MAX_BINS_DEF];
  longint           hess_tbl[ghist_pkg::MAX_BINS_DEF];
  logic [OFS_W-1:0] ofs_tbl[ghist_pkg::MAX_FEATURES_DEF];
  logic [12:0]      bin_count_m = ghist_pkg::BIN_COUNT_RST;
  logic             dense_m = ghist_pkg::DENSE_MODE_RST;

  int unsigned send_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count = 0;

  gradient_histogram_accumulator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // saturating add into a 48-bit sum
  function automatic longint sat_sum(input longint acc, input logic signed [ROW_W-1:0] delta);
    longint s;
    s = acc + longint'(delta);
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  // update the shadow tables for one accepted item, queue any readback
  function automatic void apply_histogram_item(input ghist_pkg::req_t it);
    logic [IDX_W-1:0] idx;
    int unsigned lim;
    ghist_pkg::res_t r;
    lim = (32'(bin_count_m) < ghist_pkg::MAX_BINS_DEF) ? 32'(bin_count_m)
                                                       : ghist_pkg::MAX_BINS_DEF;
    case (it.req_type)
      ghist_pkg::REQ_ACCUM: begin
        idx = {1'b0, it.bin};
        if (dense_m) idx = idx + IDX_W'(ofs_tbl[it.feature]);
        if (32'(idx) < lim) begin
          grad_tbl[idx] = sat_sum(grad_tbl[idx], it.grad);
          hess_tbl[idx] = sat_sum(hess_tbl[idx], it.hess);
        end
      end
      ghist_pkg::REQ_READ: begin
        r = '0;
        if (32'(it.bin) < lim) begin
          r.grad_sum  = grad_tbl[it.bin][SUM_W-1:0];
          r.hess_sum  = hess_tbl[it.bin][SUM_W-1:0];
          r.bin_valid = 1'b1;
        end
        readback_q.push_back(r);
      end
      ghist_pkg::REQ_LOAD_OFS: ofs_tbl[it.feature] = it.offset_value;
      default: begin
        for (int i = 0; i < ghist_pkg::MAX_BINS_DEF; i++) begin
          grad_tbl[i] = 0;
          hess_tbl[i] = 0;
        end
      end
    endcase
  endfunction

  function automatic ghist_pkg::req_t mk(input ghist_pkg::req_e rq,
                                         input logic [FEAT_W-1:0] f,
                                         input logic [BIN_W-1:0] b,
                                         input logic [ROW_W-1:0] g,
                                         input logic [ROW_W-1:0] h,
                                         input logic [OFS_W-1:0] o);
    ghist_pkg::req_t it;
    it.req_type     = rq;
    it.feature      = f;
    it.bin          = b;
    it.grad         = g;
    it.hess         = h;
    it.offset_value = o;
    return it;
  endfunction

  // row values: rails, small signed values, full random
  function automatic logic [ROW_W-1:0] pick_row();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  // global bin, mostly in the low region where accumulates land
  function automatic logic [BIN_W-1:0] hot_bin();
    case ($urandom_range(9))
      0: return BIN_W'($urandom);
      1: return BIN_W'($urandom_range(4095));
      default: return BIN_W'($urandom_range(63));
    endcase
  endfunction

  function automatic ghist_pkg::req_t rand_item();
    ghist_pkg::req_t it;
    int unsigned sel;
    it.feature      = FEAT_W'($urandom);
    it.bin          = BIN_W'($urandom);
    it.grad         = $urandom;
    it.hess         = $urandom;
    it.offset_value = OFS_W'($urandom_range(4096));
    sel = $urandom_range(199);
    if (sel < 95) begin
      it.req_type = ghist_pkg::REQ_ACCUM;
      if (dense_m) begin
        if ($urandom_range(3) != 0) it.feature = FEAT_W'($urandom_range(7));
        case ($urandom_range(9))
          0: it.bin = BIN_W'($urandom);
          1: it.bin = BIN_W'($urandom_range(4095));
          default: it.bin = BIN_W'($urandom_range(31));
        endcase
      end else begin
        it.bin = hot_bin();
      end
      it.grad = pick_row();
      it.hess = pick_row();
    end else if (sel < 160) begin
      it.req_type = ghist_pkg::REQ_READ;
      it.bin = hot_bin();
    end else if (sel < 198) begin
      it.req_type = ghist_pkg::REQ_LOAD_OFS;
      if ($urandom_range(3) != 0) begin
        it.feature = FEAT_W'($urandom_range(7));
        it.offset_value = OFS_W'($urandom_range(7) * 8);
      end
    end else begin
      it.req_type = ghist_pkg::REQ_CLEAR;
    end
    return it;
  endfunction

  // register write, only while the block is idle
  task automatic write_reg(input logic [ghist_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ghist_pkg::CNT13_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == ghist_pkg::CFG_BIN_COUNT) bin_count_m = val;
    else dense_m = val[0];
  endtask

  // wait until every item is taken, every readback is back and the block is idle
  task automatic settle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || start_i || readback_q.size() != 0);
    repeat (4) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // driver: issue the front pending item, hold it while the block is busy
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        apply_histogram_item(req_i);
        void'(pending_items.pop_front());
      end
      if (!(start_i && busy_o)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          start_i <= 1'b1;
          req_i   <= pending_items[0];
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each readback with the oldest expected one
  always @(posedge clk_i) begin
    ghist_pkg::res_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (readback_q.size() == 0) begin
        $error("readback with none expected: grad_sum %0d hess_sum %0d bin_valid %0d",
               res_o.grad_sum, res_o.hess_sum, res_o.bin_valid);
        err_count++;
      end else begin
        exp_r = readback_q.pop_front();
        if (res_o.grad_sum !== exp_r.grad_sum) begin
          $error("grad_sum: expected %0d, actual %0d", exp_r.grad_sum, res_o.grad_sum);
          err_count++;
        end
        if (res_o.hess_sum !== exp_r.hess_sum) begin
          $error("hess_sum: expected %0d, actual %0d", exp_r.hess_sum, res_o.hess_sum);
          err_count++;
        end
        if (res_o.bin_valid !== exp_r.bin_valid) begin
          $error("bin_valid: expected %0d, actual %0d", exp_r.bin_valid, res_o.bin_valid);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL gradient_histogram_accumulator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned idle_mix[4];
    idle_mix = '{0, 72, 0, 33};
    for (int i = 0; i < ghist_pkg::MAX_BINS_DEF; i++) begin
      grad_tbl[i] = 0;
      hess_tbl[i] = 0;
    end
    for (int i = 0; i < ghist_pkg::MAX_FEATURES_DEF; i++) ofs_tbl[i] = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // dense mode: offsets at the table edge, index past the limit, no wrap of bin
    pending_items.push_back(mk(ghist_pkg::REQ_LOAD_OFS, 8'd255, BIN_W'($urandom),
                               $urandom, $urandom, 13'd4096));
    pending_items.push_back(mk(ghist_pkg::REQ_LOAD_OFS, 8'd1, BIN_W'($urandom),
                               $urandom, $urandom, 13'd4095));
    pending_items.push_back(mk(ghist_pkg::REQ_LOAD_OFS, 8'd2, BIN_W'($urandom),
                               $urandom, $urandom, 13'd100));
    pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, 8'd255, 16'd0, 32'h7FFF_FFFF, 32'h1,
                               OFS_W'($urandom)));
    pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, 8'd1, 16'd0, 32'h7FFF_FFFF,
                               32'h8000_0000, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, 8'd1, 16'd1, 32'h5, 32'h5, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, 8'd2, 16'hFFFF, 32'h5, 32'h5, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, 8'd0, 16'd0, 32'hFFFF_FFFF, 32'h1,
                               13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd4095, 32'h0, 32'h0, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'hFF, 16'd4096, $urandom, $urandom,
                               OFS_W'($urandom)));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'hFFFF, 32'h0, 32'h0, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd0, 32'h0, 32'h0, 13'd0));
    settle();

    // global bins, then a clear that keeps the offsets
    write_reg(ghist_pkg::CFG_DENSE_MODE, {12'($urandom), 1'b0});
    pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, 8'd255, 16'd5, 32'h1, 32'h2, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd5, 32'h0, 32'h0, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_CLEAR, FEAT_W'($urandom), BIN_W'($urandom),
                               $urandom, $urandom, OFS_W'($urandom)));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd4095, 32'h0, 32'h0, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd5, 32'h0, 32'h0, 13'd0));
    settle();

    // no bins in use
    write_reg(ghist_pkg::CFG_BIN_COUNT, 13'd0);
    pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, 8'd0, 16'd0, 32'h10, 32'h10, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd0, 32'h0, 32'h0, 13'd0));
    settle();

    // bin count above the table size acts as the table size
    write_reg(ghist_pkg::CFG_BIN_COUNT, 13'd8191);
    pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, 8'd0, 16'd4095, 32'h8000_0000,
                               32'h7FFF_FFFF, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd4095, 32'h0, 32'h0, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd4096, 32'h0, 32'h0, 13'd0));
    settle();

    // single bin in use
    write_reg(ghist_pkg::CFG_BIN_COUNT, 13'd1);
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd0, 32'h0, 32'h0, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd1, 32'h0, 32'h0, 13'd0));
    settle();

    // pile extreme rows onto one bin back to back, then back off
    write_reg(ghist_pkg::CFG_BIN_COUNT, 13'd4096);
    for (int i = 0; i < RAIL_ADDS; i++) begin
      pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, FEAT_W'($urandom), 16'd7,
                                 32'h7FFF_FFFF, 32'h8000_0000, OFS_W'($urandom)));
      if (i == RAIL_ADDS - 2)
        pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd7, 32'h0, 32'h0, 13'd0));
    end
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd7, 32'h0, 32'h0, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_ACCUM, 8'd0, 16'd7, 32'h8000_0000,
                               32'h7FFF_FFFF, 13'd0));
    pending_items.push_back(mk(ghist_pkg::REQ_READ, 8'd0, 16'd7, 32'h0, 32'h0, 13'd0));
    settle();

    // random phases with varied sender idling and register settings
    for (int p = 0; p < 4; p++) begin
      write_reg(ghist_pkg::CFG_DENSE_MODE,
                {12'($urandom), (p % 2 == 0) ? 1'b1 : 1'($urandom)});
      case ($urandom_range(5))
        0: write_reg(ghist_pkg::CFG_BIN_COUNT, 13'd8191);
        1: write_reg(ghist_pkg::CFG_BIN_COUNT, 13'($urandom_range(1, 64)));
        2: write_reg(ghist_pkg::CFG_BIN_COUNT, 13'($urandom_range(8191)));
        default: write_reg(ghist_pkg::CFG_BIN_COUNT, 13'd4096);
      endcase
      send_idle_pct = idle_mix[p];
      for (int i = 0; i < PHASE_ITEMS; i++) pending_items.push_back(rand_item());
      settle();
    end

    if (err_count == 0 && readback_q.size() == 0) begin
      $display("PASS gradient_histogram_accumulator");
    end else begin
      $display("FAIL gradient_histogram_accumulator");
    end
    $finish;
  end

endmodule
